// ===== src/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
package spq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountOutW   = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [DataW-1:0] data;
    logic [DataW-1:0] prio;
  } spq_cmd_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic             valid;
    logic             after;
    logic [DataW-1:0] data;
    logic [DataW-1:0] prio;
  } spq_link_t;

endpackage

// ===== src/spq_cell.sv =====
// one slot of the sorted shift-register queue
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  spq_cmd_t  cmd_i,
  input  spq_link_t left_i,
  input  spq_link_t right_i,
  output spq_link_t self_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] prio_q, prio_d;
  logic             after;

  // entry stays ahead of the new key when it is held and not greater
  assign after = valid_q && ($signed(prio_q) <= $signed(cmd_i.prio));

  // next slot contents
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    if (cmd_i.ins) begin
      valid_d = valid_q | left_i.valid;
      if (!after) begin
        if (left_i.after) begin
          data_d = cmd_i.data;
          prio_d = cmd_i.prio;
        end else begin
          data_d = left_i.data;
          prio_d = left_i.prio;
        end
      end
    end else if (cmd_i.rem) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
      prio_d  = right_i.prio;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign self_o.valid = valid_q;
  assign self_o.after = after;
  assign self_o.data  = data_q;
  assign self_o.prio  = prio_q;

`ifndef SYNTH
  // order holds against the right neighbor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && right_i.valid |-> $signed(prio_q) <= $signed(right_i.prio))
    else $error("spq_cell: entries out of order");

  // a held entry never follows an empty slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> left_i.valid)
    else $error("spq_cell: gap in the queue");

  // a remove pulls in the right neighbor's flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rem |=> valid_q == $past(right_i.valid))
    else $error("spq_cell: remove did not shift the slot");
`endif

endmodule

// ===== src/sorted_priority_queue.sv =====
// sorted priority queue: a row of cells that shift as entries come and go
// the result register loads at the edge that accepts the item
// throughput: one insert or remove per cycle while no result is stuck in the output register
// every cell compares the new key against its own entry in parallel
// reset clears the cell valid flags, the count and the result valid; payloads are not reset
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [DataW-1:0]     data_value_i,
  input  logic [DataW-1:0]     priority_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [StatusW-1:0]   status_o,
  output logic [DataW-1:0]     removed_data_o,
  output logic [DataW-1:0]     removed_priority_o,
  output logic [CountOutW-1:0] entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW = (CntW > CountOutW) ? CntW : CountOutW;

  logic                accept;
  logic                full, empty;
  logic [CntW-1:0]     count_q, count_d;
  spq_cmd_t            cmd;
  spq_link_t           links [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;

  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [DataW-1:0]    rdata_q, rdata_d;
  logic [DataW-1:0]    rprio_q, rprio_d;
  logic [CntW-1:0]     rcount_q;
  logic [ExtW-1:0]     rcount_ext;

  // handshake: take an item unless a result is stuck in the output register
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  // command to all cells
  always_comb begin
    cmd.ins  = accept && (op_e'(operation_i) == OP_INSERT) && !full;
    cmd.rem  = accept && (op_e'(operation_i) == OP_REMOVE) && !empty;
    cmd.data = data_value_i;
    cmd.prio = priority_req_i;
  end

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = '{valid: 1'b1, after: 1'b1, data: '0, prio: '0};
    end else begin : g_mid
      assign left_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = '0;
    end else begin : g_body
      assign right_l = links[i+1];
    end
    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_l),
      .right_i (right_l),
      .self_o  (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // result for the accepted item
  always_comb begin
    status_d = ST_DONE;
    rdata_d  = '0;
    rprio_d  = '0;
    if (op_e'(operation_i) == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      rdata_d = links[0].data;
      rprio_d = links[0].prio;
    end
  end

  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
      rprio_q  <= rprio_d;
      rcount_q <= count_d;
    end
  end

  assign rcount_ext         = ExtW'(rcount_q);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_data_o     = rdata_q;
  assign removed_priority_o = rprio_q;
  assign entry_count_o      = rcount_ext[CountOutW-1:0];

`ifndef SYNTH
  // count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("sorted_priority_queue: count beyond capacity");

  // count agrees with the cells that hold entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("sorted_priority_queue: count and cell flags disagree");

  // a dropped insert leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_e'(operation_i) == OP_INSERT) && full |=> $stable(count_q))
    else $error("sorted_priority_queue: full insert changed the queue");

  // a remove from a non-empty queue takes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> count_q == $past(count_q) - CntW'(1))
    else $error("sorted_priority_queue: remove miscounted");
`endif

endmodule
